// ===== rtl/lrl_pkg.sv =====
package lrl_pkg;

   // Fixed field widths of the request and response transactions
   localparam int KEY_W   = 64;
   localparam int COUNT_W = 7;

   // Defaults for the top-level parameters
   localparam int DEF_CAPACITY = 64;
   localparam int DEF_KEY_BITS = 64;

   // Command codes
   localparam logic [1:0] CMD_ACCESS = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;
   localparam logic [1:0] CMD_LOOKUP = 2'd3;

   // Per-cell update modes
   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_MOVE   = 2'd1;
   localparam logic [1:0] MODE_INSERT = 2'd2;
   localparam logic [1:0] MODE_REMOVE = 2'd3;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [KEY_W-1:0]   oldest_key;
      logic [COUNT_W-1:0] entry_count;
      logic               full_drop;
   } rsp_type;

   typedef struct packed {
      logic       cmp_en;
      logic       apply;
      logic [1:0] mode;
   } cell_ctrl_type;

endpackage

// ===== rtl/lrl_cell.sv =====
module lrl_cell #(
   parameter int KEY_BITS = lrl_pkg::DEF_KEY_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrl_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]    key_bcast,
   input  logic                   prev_valid,
   input  logic                   next_valid,
   input  logic [KEY_BITS-1:0]    next_key,
   input  logic                   chain_in,
   output logic [KEY_BITS-1:0]    key_out,
   output logic                   valid_out,
   output logic                   hit_out,
   output logic                   chain_out
);
   import lrl_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                valid_ff, valid_in;
   logic                hit_ff, hit_in;

   // Set when the matching entry sits in this cell or an older one
   assign chain_out = chain_in | hit_ff;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      hit_in   = hit_ff;
      if (ctrl.cmp_en) begin
         hit_in = valid_ff && (key_ff == key_bcast);
      end
      if (ctrl.apply) begin
         unique case (ctrl.mode)
            MODE_MOVE: begin
               // close the gap; the last valid cell takes the accessed key
               if (chain_out && valid_ff) begin
                  if (next_valid) begin
                     key_in = next_key;
                  end else begin
                     key_in = key_bcast;
                  end
               end
            end
            MODE_INSERT: begin
               if (prev_valid && !valid_ff) begin
                  key_in   = key_bcast;
                  valid_in = 1'b1;
               end
            end
            MODE_REMOVE: begin
               if (chain_out) begin
                  key_in   = next_key;
                  valid_in = next_valid;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   assign key_out   = key_ff;
   assign valid_out = valid_ff;
   assign hit_out   = hit_ff;

endmodule

// ===== rtl/lru_recency_list.sv =====
// A request is accepted into the match step (ST_CMP) across the cell chain, then the shift /
//   load of the cells (ST_APPLY), where the response register is loaded once the output
//   register is free; the next request is taken in that shift step, and not before it.
// Reset (synchronous, active high) clears the cell valid bits, the count and the sequencer;
//   stored keys are not cleared and no clearing pass runs.
module lru_recency_list #(
   parameter int CAPACITY = lrl_pkg::DEF_CAPACITY,
   parameter int KEY_BITS = lrl_pkg::DEF_KEY_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lrl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lrl_pkg::rsp_type rsp_data
);
   import lrl_pkg::*;

   // Entries are kept compacted: cell 0 holds the least recent key, the
   // newest key sits in the highest valid cell. Pop and remove shift the
   // cells above the victim down by one; an access hit does the same and
   // drops the key into the last valid cell; an insert fills the first
   // free cell.

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                apply_go;
   logic                req_accept;
   logic                found_any;
   logic                is_full;
   cell_ctrl_type       ctrl;

   logic [KEY_BITS-1:0] key_vec [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;
   logic [CAPACITY-1:0] hit_vec;
   logic [CAPACITY:0]   chain_vec;

   // Result can leave the shift cycle only when the output register is free
   assign apply_go   = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = (state_ff == ST_IDLE) || apply_go;
   assign req_accept = req_valid && req_ready;

   assign found_any = |hit_vec;
   assign is_full   = valid_vec[CAPACITY-1];

   // Cell control: compare in ST_CMP, update in the shift cycle
   always_comb begin
      ctrl.cmp_en = (state_ff == ST_CMP);
      ctrl.apply  = apply_go;
      ctrl.mode   = MODE_HOLD;
      unique case (cmd_ff)
         CMD_ACCESS: begin
            if (found_any) begin
               ctrl.mode = MODE_MOVE;
            end else if (!is_full) begin
               ctrl.mode = MODE_INSERT;
            end
         end
         CMD_REMOVE: begin
            if (found_any) begin
               ctrl.mode = MODE_REMOVE;
            end
         end
         CMD_POP:    ctrl.mode = MODE_REMOVE;
         CMD_LOOKUP: ctrl.mode = MODE_HOLD;
         default:    ctrl.mode = MODE_HOLD;
      endcase
   end

   // Pop shifts the whole chain: inject the shift flag at the oldest end
   assign chain_vec[0] = (cmd_ff == CMD_POP);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                prev_v;
      logic                next_v;
      logic [KEY_BITS-1:0] next_k;

      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
      end else begin : g_mid
         assign prev_v = valid_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_v = 1'b0;
         assign next_k = '0;
      end else begin : g_inner
         assign next_v = valid_vec[i+1];
         assign next_k = key_vec[i+1];
      end

      lrl_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key_bcast  (key_ff),
         .prev_valid (prev_v),
         .next_valid (next_v),
         .next_key   (next_k),
         .chain_in   (chain_vec[i]),
         .key_out    (key_vec[i]),
         .valid_out  (valid_vec[i]),
         .hit_out    (hit_vec[i]),
         .chain_out  (chain_vec[i+1])
      );
   end

   // Response and count for the transaction in the shift cycle
   always_comb begin
      held_in            = held_ff;
      rsp_in             = rsp_ff;
      rsp_in.found       = 1'b0;
      rsp_in.oldest_key  = '0;
      rsp_in.full_drop   = 1'b0;
      unique case (cmd_ff)
         CMD_ACCESS: begin
            rsp_in.found = found_any;
            if (!found_any) begin
               if (is_full) begin
                  rsp_in.full_drop = 1'b1;
               end else begin
                  held_in = held_ff + CNT_W'(1);
               end
            end
         end
         CMD_REMOVE: begin
            rsp_in.found = found_any;
            if (found_any) begin
               held_in = held_ff - CNT_W'(1);
            end
         end
         CMD_POP: begin
            rsp_in.found = valid_vec[0];
            if (valid_vec[0]) begin
               rsp_in.oldest_key = KEY_W'(key_vec[0]);
               held_in           = held_ff - CNT_W'(1);
            end
         end
         CMD_LOOKUP: rsp_in.found = found_any;
         default:    rsp_in.found = 1'b0;
      endcase
      rsp_in.entry_count = COUNT_W'(held_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: state_in = ST_APPLY;
         ST_APPLY: begin
            if (req_accept) begin
               state_in = ST_CMP;
            end else if (apply_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_data.cmd;
         key_ff <= req_data.key[KEY_BITS-1:0];
      end
      if (apply_go) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_go) begin
            held_ff <= held_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Count always tracks the number of occupied cells
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      held_ff == CNT_W'($countones(valid_vec)))
      else $error("entry count differs from occupied cells");

   // Keys are distinct, so at most one cell matches
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell matched");

   // A refused insert is only reported with every cell occupied
   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.full_drop |-> is_full)
      else $error("full_drop reported with free cells");

   // Occupied cells stay packed toward the oldest end
   a_cells_compact: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("gap in occupied cells");

endmodule

// ===== sim/lru_recency_list_test.sv =====
`timescale 1ns / 100ps

module lru_recency_list_test;
   import lrl_pkg::*;

   localparam int CAPACITY = DEF_CAPACITY;
   localparam int KEY_BITS = DEF_KEY_BITS;
   localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}}
                                           : ((64'd1 << KEY_BITS) - 64'd1);
   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS = 1250;
   localparam int POOL_MAX = 256;

   // Recency predictor plus the queue of responses still owed by the block.
   class lru_scoreboard;
      logic [KEY_W-1:0] recency_q[$];   // [0] is least recent
      rsp_type          owed_q[$];
      int               error_count;

      function new();
         error_count = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Advance the predicted list by one request and queue the response.
      function void note_request(req_type r);
         rsp_type          e;
         logic [KEY_W-1:0] k;
         int               hit;
         e = '0;
         k = r.key & KEY_MASK;
         hit = -1;
         foreach (recency_q[i])
            if (recency_q[i] == k) hit = i;
         case (r.cmd)
            CMD_ACCESS: begin
               if (hit >= 0) begin
                  // hit: move to the most recent end
                  e.found = 1'b1;
                  recency_q.delete(hit);
                  recency_q.push_back(k);
               end else if (recency_q.size() >= CAPACITY) begin
                  // miss on a full store: refused, order untouched
                  e.full_drop = 1'b1;
               end else begin
                  recency_q.push_back(k);
               end
            end
            CMD_REMOVE: begin
               if (hit >= 0) begin
                  e.found = 1'b1;
                  recency_q.delete(hit);
               end
            end
            CMD_LOOKUP: begin
               if (hit >= 0) e.found = 1'b1;
            end
            default: begin
               // pop of the least recent key; empty store leaves all zero
               if (recency_q.size() > 0) begin
                  e.found = 1'b1;
                  e.oldest_key = recency_q.pop_front();
               end
            end
         endcase
         e.entry_count = COUNT_W'(recency_q.size());
         owed_q.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (owed_q.size() == 0) begin
            $error("response with nothing outstanding: %0h", a);
            error_count++;
            return;
         end
         e = owed_q.pop_front();
         if (a.found !== e.found) begin
            $error("found: expected %0h actual %0h", e.found, a.found);
            error_count++;
         end
         if (a.oldest_key !== e.oldest_key) begin
            $error("oldest_key: expected %0h actual %0h", e.oldest_key, a.oldest_key);
            error_count++;
         end
         if (a.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d actual %0d", e.entry_count, a.entry_count);
            error_count++;
         end
         if (a.full_drop !== e.full_drop) begin
            $error("full_drop: expected %0h actual %0h", e.full_drop, a.full_drop);
            error_count++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shared pacing controls: quiet turns off idling on both sides,
   // hold_request asks the receiver for one long back-pressure stretch
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int idle_cycles = 0;

   lru_scoreboard sb = new();

   lru_recency_list u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Transaction monitor. Values read right after the edge are the ones the
   // block saw at that edge. The response is checked before the request is
   // noted; a response can never belong to a request taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
      end
   end

   // Watchdog: count consecutive cycles with no transaction on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random ready, ~25% low, except in the quiet stretch; on
   // request it holds ready low for a long stretch counted here.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 25);
         end
      end
   end

   // Offer one request and return at the edge where it is taken. Valid is
   // only dropped when a gap is inserted, so back-to-back transactions keep
   // it high with a single assignment per step.
   task automatic send_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
      if (!quiet && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 25);
      end
      req_valid    <= 1'b1;
      req_data.cmd <= cmd;
      req_data.key <= key;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic [KEY_W-1:0] pool[POOL_MAX];
      logic [KEY_W-1:0] k;
      logic [1:0]       c;
      int               pool_size, pct_access, pct_remove, pct_pop, roll;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty-store corners, key extremes, reorder on hit ---
      send_request(CMD_POP,    {KEY_W{1'b1}});        // pop while empty
      send_request(CMD_LOOKUP, '0);                   // lookup miss
      send_request(CMD_REMOVE, '0);                   // remove of absent key
      send_request(CMD_ACCESS, '0);                   // insert smallest key
      send_request(CMD_ACCESS, {KEY_W{1'b1}});        // insert largest key
      send_request(CMD_ACCESS, 64'h5555_5555_5555_5555);
      send_request(CMD_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(CMD_LOOKUP, {KEY_W{1'b1}});        // hit, no reorder
      send_request(CMD_ACCESS, '0);                   // hit moves oldest to newest
      send_request(CMD_POP,    '0);                   // now returns all-ones key
      send_request(CMD_REMOVE, 64'h5555_5555_5555_5555);
      send_request(CMD_REMOVE, 64'h5555_5555_5555_5555);  // second remove misses
      send_request(CMD_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA);  // hit on the oldest
      send_request(CMD_POP,    64'h1234);             // returns zero key
      send_request(CMD_POP,    '0);
      send_request(CMD_POP,    '0);                   // empty again
      send_request(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(CMD_ACCESS, 64'h8000_0000_0000_0001);
      send_request(CMD_LOOKUP, 64'h8000_0000_0000_0001);
      send_request(CMD_REMOVE, 64'h8000_0000_0000_0001); // store empties

      // --- random: phases over key pools of different sizes. Large pools with
      // heavy access fill the store and hit the full-refusal path; small pools
      // give dense hits, reorders and pops.
      pool_size  = 1;
      pct_access = 0;
      pct_remove = 0;
      pct_pop    = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 125 == 0) begin
            case ((n / 125) % 5)
               0: begin pool_size = 200; pct_access = 95; pct_remove = 2;  pct_pop = 2;  end
               1: begin pool_size = 16;  pct_access = 40; pct_remove = 20; pct_pop = 20; end
               2: begin pool_size = 70;  pct_access = 70; pct_remove = 10; pct_pop = 10; end
               3: begin pool_size = 4;   pct_access = 30; pct_remove = 30; pct_pop = 20; end
               default: begin
                  pool_size = 200; pct_access = 50; pct_remove = 10; pct_pop = 30;
               end
            endcase
            for (int i = 0; i < pool_size; i++) pool[i] = random_key();
         end
         quiet = (n >= 350 && n < 600);
         if (n == 800) hold_request = 1'b1;   // receiver backs off, block fills up

         roll = $urandom_range(99);
         if (roll < pct_access)                               c = CMD_ACCESS;
         else if (roll < pct_access + pct_remove)             c = CMD_REMOVE;
         else if (roll < pct_access + pct_remove + pct_pop)   c = CMD_POP;
         else                                                 c = CMD_LOOKUP;

         roll = $urandom_range(99);
         if (c == CMD_POP || roll < 10) k = random_key();   // mostly misses
         else k = pool[$urandom_range(pool_size - 1)];
         send_request(c, k);
      end

      req_valid <= 1'b0;
      quiet = 1'b0;

      // drain, then a few extra cycles to catch any stray response
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== lru_recency_list.f =====
rtl/lrl_pkg.sv
rtl/lrl_cell.sv
rtl/lru_recency_list.sv
sim/lru_recency_list_test.sv
